### hdl/homogeneous_transform_engine_unit_macros.svh
// Assertion macros for the transform engine.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef HOMOGENEOUS_TRANSFORM_ENGINE_UNIT_MACROS_SVH
`define HOMOGENEOUS_TRANSFORM_ENGINE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HTE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define HTE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### hdl/hte_pkg.sv
// Shared types, codes and helpers for the transform engine.
// No dependencies.
package hte_pkg;

    localparam int DIM_DEF       = 4;
    localparam int WORD_BITS_DEF = 32;
    localparam int DATA_BITS     = 32;   // stored element width
    localparam int FRAC_BITS     = 16;
    localparam int COL_BITS      = 2;    // enough for DIM of 3 or 4

    // function codes of an item
    localparam logic [2:0] FN_LOAD   = 3'd0;
    localparam logic [2:0] FN_XFORM  = 3'd1;
    localparam logic [2:0] FN_TRANS  = 3'd2;
    localparam logic [2:0] FN_SCALE  = 3'd3;
    localparam logic [2:0] FN_ROTATE = 3'd4;
    // spare codes: matrix untouched, all-zero result
    localparam logic [2:0] FN_RSV5   = 3'd5;
    localparam logic [2:0] FN_RSV6   = 3'd6;
    localparam logic [2:0] FN_RSV7   = 3'd7;

    // rotation axes
    localparam logic [1:0] AX_X    = 2'd0;
    localparam logic [1:0] AX_Y    = 2'd1;
    localparam logic [1:0] AX_Z    = 2'd2;
    localparam logic [1:0] AX_NONE = 2'd3;   // no rotation

    typedef enum logic [2:0] {
        K_NOP,
        K_ACC,
        K_MUL,
        K_LOAD,
        K_TRAN
    } step_kind_t;

    // one column step handed from the sequencer to the datapath
    typedef struct packed {
        logic                        vld;
        step_kind_t                  kind;
        logic                        head;
        logic                        wr;
        logic                        last;
        logic                        emit;
        logic                        vec;
        logic [COL_BITS-1:0]         ra;
        logic [COL_BITS-1:0]         rb;
        logic [COL_BITS-1:0]         wcol;
        logic [1:0]                  row;
        logic signed [DATA_BITS-1:0] ka;
        logic signed [DATA_BITS-1:0] kb;
        logic signed [DATA_BITS-1:0] tx;
        logic signed [DATA_BITS-1:0] ty;
        logic signed [DATA_BITS-1:0] tz;
    } step_t;

    // clamp to a signed range of the given width
    function automatic logic signed [63:0] sat_word(input logic signed [63:0] v,
                                                    input int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

endpackage

### hdl/hte_if.sv
// Item channels of the transform engine: input and result.
// Uses no package.
interface hte_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [1:0]         col_index;
    logic [1:0]         row_index;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic [1:0]         rotation_axis;
    logic signed [17:0] angle_cos;
    logic signed [17:0] angle_sin;

    modport source (output valid, func, col_index, row_index, in_x, in_y, in_z, in_w,
                    rotation_axis, angle_cos, angle_sin, input ready);
    modport sink (input valid, func, col_index, row_index, in_x, in_y, in_z, in_w,
                  rotation_axis, angle_cos, angle_sin, output ready);
endinterface

interface hte_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               is_vector;

    modport source (output valid, out_x, out_y, out_z, out_w, is_vector, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, is_vector, output ready);
endinterface

### hdl/hte_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module hte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read ports, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### hdl/hte_seq.sv
// Item sequencer: holds the current item and issues its column steps.
// Depends on hte_pkg and hte_in_if.
module hte_seq #(
    parameter int DIM       = hte_pkg::DIM_DEF,
    parameter int WORD_BITS = hte_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    hte_in_if.sink                       in_ch,
    input  logic                         adv,
    input  logic                         hazard,
    output hte_pkg::step_t               step,
    output logic                         re,
    output logic [hte_pkg::COL_BITS-1:0] raddr_a,
    output logic [hte_pkg::COL_BITS-1:0] raddr_b
);

    localparam int EFF = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam logic [hte_pkg::COL_BITS-1:0] LAST_COL = hte_pkg::COL_BITS'(DIM - 1);

    logic                     busy_reg;
    logic [1:0]               step_reg;
    logic [2:0]               func_reg;
    logic [1:0]               ci_reg;
    logic [1:0]               ri_reg;
    logic [1:0]               axis_reg;
    logic signed [31:0]       x_reg;
    logic signed [31:0]       y_reg;
    logic signed [31:0]       z_reg;
    logic signed [31:0]       w_reg;
    logic signed [17:0]       cs_reg;
    logic signed [17:0]       sn_reg;

    logic [1:0]               last_step;
    logic                     issue;
    logic                     is_last;
    logic                     accept;
    logic signed [31:0]       v_sel;
    logic signed [31:0]       v_sat;
    logic signed [31:0]       cs32;
    logic signed [31:0]       sn32;
    logic signed [31:0]       nsn32;
    hte_pkg::step_t           st;

    // index of the last column step of each item
    always_comb
    begin
        case (func_reg)
            hte_pkg::FN_XFORM:  last_step = 2'(DIM - 1);
            hte_pkg::FN_SCALE:  last_step = 2'd2;
            hte_pkg::FN_ROTATE: last_step = (axis_reg == hte_pkg::AX_NONE) ? 2'd0 : 2'd1;
            default:            last_step = 2'd0;
        endcase
    end

    // a new item's first step waits for earlier write-backs
    assign issue   = busy_reg && adv && !(step_reg == 2'd0 && hazard);
    assign is_last = (step_reg == last_step);
    assign in_ch.ready = !busy_reg || (issue && is_last);
    assign accept  = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            step_reg <= 2'd0;
        end
        else if (issue && is_last)
            busy_reg <= 1'b0;
        else if (issue)
            step_reg <= step_reg + 2'd1;
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= in_ch.func;
            ci_reg   <= in_ch.col_index;
            ri_reg   <= in_ch.row_index;
            axis_reg <= in_ch.rotation_axis;
            x_reg    <= in_ch.in_x;
            y_reg    <= in_ch.in_y;
            z_reg    <= in_ch.in_z;
            w_reg    <= in_ch.in_w;
            cs_reg   <= in_ch.angle_cos;
            sn_reg   <= in_ch.angle_sin;
        end
    end

    // component for this step, saturated to the word range
    always_comb
    begin
        case (step_reg)
            2'd0:    v_sel = x_reg;
            2'd1:    v_sel = y_reg;
            2'd2:    v_sel = z_reg;
            default: v_sel = w_reg;
        endcase
    end

    assign v_sat = 32'(hte_pkg::sat_word(64'(v_sel), EFF));
    assign cs32  = 32'(cs_reg);
    assign sn32  = 32'(sn_reg);
    assign nsn32 = -sn32;

    // build the step
    always_comb
    begin
        st      = '0;
        st.vld  = issue;
        st.head = (step_reg == 2'd0);
        st.last = is_last;
        st.emit = is_last;
        st.ra   = hte_pkg::COL_BITS'(step_reg);
        st.rb   = hte_pkg::COL_BITS'(step_reg);
        st.wcol = hte_pkg::COL_BITS'(step_reg);
        st.row  = ri_reg;
        st.tx   = x_reg;
        st.ty   = y_reg;
        st.tz   = z_reg;
        st.kind = hte_pkg::K_NOP;
        case (func_reg)
            hte_pkg::FN_LOAD:
            begin
                st.kind = hte_pkg::K_LOAD;
                st.ra   = hte_pkg::COL_BITS'(ci_reg);
                st.rb   = hte_pkg::COL_BITS'(ci_reg);
                st.wcol = hte_pkg::COL_BITS'(ci_reg);
                st.ka   = 32'(hte_pkg::sat_word(64'(x_reg), EFF));
                st.wr   = (32'(ci_reg) < DIM) && (32'(ri_reg) < DIM);
            end
            hte_pkg::FN_XFORM:
            begin
                st.kind = hte_pkg::K_ACC;
                st.ka   = v_sat;
                st.vec  = 1'b1;
            end
            hte_pkg::FN_TRANS:
            begin
                st.kind = hte_pkg::K_TRAN;
                st.ra   = LAST_COL;
                st.rb   = LAST_COL;
                st.wcol = LAST_COL;
                st.wr   = 1'b1;
            end
            hte_pkg::FN_SCALE:
            begin
                st.kind = hte_pkg::K_MUL;
                st.ka   = v_sat;
                st.wr   = 1'b1;
            end
            hte_pkg::FN_ROTATE:
            begin
                // column pair (a, b): a' = a*c + b*p, b' = a*q + b*c
                st.kind = hte_pkg::K_MUL;
                st.wr   = 1'b1;
                case (axis_reg)
                    hte_pkg::AX_X:
                    begin
                        st.ra = 2'd1;
                        st.rb = 2'd2;
                        st.ka = (step_reg == 2'd0) ? cs32 : nsn32;
                        st.kb = (step_reg == 2'd0) ? sn32 : cs32;
                    end
                    hte_pkg::AX_Y:
                    begin
                        st.ra = 2'd0;
                        st.rb = 2'd2;
                        st.ka = (step_reg == 2'd0) ? cs32 : sn32;
                        st.kb = (step_reg == 2'd0) ? nsn32 : cs32;
                    end
                    hte_pkg::AX_Z:
                    begin
                        st.ra = 2'd0;
                        st.rb = 2'd1;
                        st.ka = (step_reg == 2'd0) ? cs32 : nsn32;
                        st.kb = (step_reg == 2'd0) ? sn32 : cs32;
                    end
                    default:
                    begin
                        st.kind = hte_pkg::K_NOP;
                        st.wr   = 1'b0;
                    end
                endcase
                st.wcol = (step_reg == 2'd0) ? st.ra : st.rb;
            end
            default:
            begin
                st.kind = hte_pkg::K_NOP;
            end
        endcase
    end

    assign step    = st;
    assign re      = issue;
    assign raddr_a = st.ra;
    assign raddr_b = st.rb;

endmodule

### hdl/hte_dp.sv
// Datapath: column multiply, sum and saturate, write-back and result register.
// Depends on hte_pkg and hte_out_if.
module hte_dp #(
    parameter int DIM       = hte_pkg::DIM_DEF,
    parameter int WORD_BITS = hte_pkg::WORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hte_pkg::step_t                      s0,
    input  logic [DIM*hte_pkg::DATA_BITS-1:0]   rdata_a,
    input  logic [DIM*hte_pkg::DATA_BITS-1:0]   rdata_b,
    output logic                                adv,
    output logic                                hazard,
    output logic                                we,
    output logic [hte_pkg::COL_BITS-1:0]        waddr,
    output logic [DIM*hte_pkg::DATA_BITS-1:0]   wdata,
    hte_out_if.source                           out_ch
);

    localparam int EFF = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int DW  = hte_pkg::DATA_BITS;
    localparam int PW  = 2 * DW - hte_pkg::FRAC_BITS;   // floored product
    localparam int SW  = PW + 2;                        // sum of four products
    localparam logic signed [DW-1:0] ONE_Q = DW'(1) <<< hte_pkg::FRAC_BITS;

    hte_pkg::step_t        s1_reg;
    hte_pkg::step_t        s2_reg;
    logic [DIM-1:0]        col_vld_reg;
    logic signed [PW-1:0]  pa_reg  [DIM];
    logic signed [PW-1:0]  pb_reg  [DIM];
    logic signed [DW-1:0]  nv_reg  [DIM];
    logic signed [SW-1:0]  acc_reg [DIM];
    logic                  out_vld_reg;
    logic signed [DW-1:0]  out_reg [4];
    logic                  out_vec_reg;

    logic signed [DW-1:0]  a_col [DIM];
    logic signed [DW-1:0]  b_col [DIM];
    logic signed [PW-1:0]  pa    [DIM];
    logic signed [PW-1:0]  pb    [DIM];
    logic signed [DW-1:0]  nv    [DIM];
    logic signed [SW-1:0]  sum   [DIM];
    logic signed [DW-1:0]  wv    [DIM];
    logic signed [DW-1:0]  res   [DIM];

    assign adv    = !out_vld_reg || out_ch.ready;
    assign hazard = (s1_reg.vld && s1_reg.wr) || (s2_reg.vld && s2_reg.wr);

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= s0;
            s2_reg <= s1_reg;
        end
    end

    // stage 1: unwritten columns read as identity, then multiply
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            logic signed [2*DW-1:0] pra;
            logic signed [2*DW-1:0] prb;
            logic signed [DW-1:0]   t;
            a_col[r] = col_vld_reg[s1_reg.ra] ? $signed(rdata_a[r*DW +: DW])
                     : ((s1_reg.ra == hte_pkg::COL_BITS'(r)) ? ONE_Q : '0);
            b_col[r] = col_vld_reg[s1_reg.rb] ? $signed(rdata_b[r*DW +: DW])
                     : ((s1_reg.rb == hte_pkg::COL_BITS'(r)) ? ONE_Q : '0);
            pra   = a_col[r] * s1_reg.ka;
            prb   = b_col[r] * s1_reg.kb;
            pa[r] = pra[2*DW-1:hte_pkg::FRAC_BITS];
            pb[r] = prb[2*DW-1:hte_pkg::FRAC_BITS];
            case (r)
                0:       t = s1_reg.tx;
                1:       t = s1_reg.ty;
                default: t = s1_reg.tz;
            endcase
            if (s1_reg.kind == hte_pkg::K_LOAD)
                nv[r] = (s1_reg.row == 2'(r)) ? s1_reg.ka : a_col[r];
            else if (r < DIM - 1)
                nv[r] = DW'(hte_pkg::sat_word(64'(a_col[r]) + 64'(t), EFF));
            else
                nv[r] = a_col[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                pa_reg[r] <= pa[r];
                pb_reg[r] <= pb[r];
                nv_reg[r] <= nv[r];
            end
        end
    end

    // stage 2: sum, saturate, accumulate and pick the write-back data
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            sum[r] = (s2_reg.head ? SW'(0) : acc_reg[r]) + SW'(pa_reg[r]);
            res[r] = DW'(hte_pkg::sat_word(64'(sum[r]), EFF));
            if (s2_reg.kind == hte_pkg::K_MUL)
                wv[r] = DW'(hte_pkg::sat_word(64'(pa_reg[r]) + 64'(pb_reg[r]), EFF));
            else
                wv[r] = nv_reg[r];
            wdata[r*DW +: DW] = wv[r];
        end
    end

    assign we    = adv && s2_reg.vld && s2_reg.wr;
    assign waddr = s2_reg.wcol;

    always_ff @(posedge clk)
    begin
        if (adv && s2_reg.vld && s2_reg.kind == hte_pkg::K_ACC)
        begin
            for (int r = 0; r < DIM; r++)
                acc_reg[r] <= sum[r];
        end
    end

    // columns written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_vld_reg <= '0;
        else if (we)
            col_vld_reg[waddr] <= 1'b1;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= s2_reg.vld && s2_reg.emit;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_reg.vld && s2_reg.emit)
        begin
            out_vec_reg <= s2_reg.vec;
            for (int r = 0; r < 4; r++)
                out_reg[r] <= (s2_reg.vec && r < DIM) ? res[r] : '0;
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.out_x     = out_reg[0];
    assign out_ch.out_y     = out_reg[1];
    assign out_ch.out_z     = out_reg[2];
    assign out_ch.out_w     = out_reg[3];
    assign out_ch.is_vector = out_vec_reg;

endmodule

### hdl/homogeneous_transform_engine_unit.sv
// Transform engine top level: sequencer, matrix RAM and datapath.
// Depends on hte_pkg, hte_if, hte_ram, hte_seq, hte_dp and the macro header.
//
// Usage:
//   in_ch  carries one item per valid/ready handshake: load element,
//          transform vector, translate, scale or rotate.
//   out_ch returns exactly one result item per input item, in order.
//   The matrix sits in a RAM of DIM column words; each step reads a column
//   (two for a rotation) and writes at most one back from stage 2.
//   Steps: a transform takes DIM column steps (one column of DIM multiply-
//   accumulates per cycle while the pipeline advances); load, translate,
//   unused codes and a rotation with no axis take 1 step, rotate 2, scale
//   3. An item that follows a matrix write waits for the write-back to
//   land (read-modify-write interlock). The result of an item passes the
//   stage-1 and stage-2 registers into the result register after its
//   last step is issued.
//   Reset: the matrix reads as identity; per-column valid flops cleared at
//   reset stand in for the RAM until a column is first written.
//   Stall: a held result freezes the pipeline; if the sequencer is idle one
//   more item is still taken into its item register.
`include "homogeneous_transform_engine_unit_macros.svh"

module homogeneous_transform_engine_unit #(
    parameter int DIM       = hte_pkg::DIM_DEF,
    parameter int WORD_BITS = hte_pkg::WORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hte_in_if.sink    in_ch,
    hte_out_if.source out_ch
);

    localparam int RW = DIM * hte_pkg::DATA_BITS;

    hte_pkg::step_t                step;
    logic                          re;
    logic [hte_pkg::COL_BITS-1:0]  raddr_a;
    logic [hte_pkg::COL_BITS-1:0]  raddr_b;
    logic [RW-1:0]                 rdata_a;
    logic [RW-1:0]                 rdata_b;
    logic                          adv;
    logic                          hazard;
    logic                          we;
    logic [hte_pkg::COL_BITS-1:0]  waddr;
    logic [RW-1:0]                 wdata;

    hte_seq #(
        .DIM       (DIM),
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .adv     (adv),
        .hazard  (hazard),
        .step    (step),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b)
    );

    hte_ram #(
        .WIDTH (RW),
        .DEPTH (DIM)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    hte_dp #(
        .DIM       (DIM),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s0      (step),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .adv     (adv),
        .hazard  (hazard),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .out_ch  (out_ch)
    );

    // checks
    `HTE_ASSERT_IMPLY(a_head_no_hazard, step.vld && step.head, !hazard, "item issued over pending write")
    `HTE_ASSERT_NEVER(a_no_rw_overlap, we && re && (raddr_a == waddr || raddr_b == waddr), "read of a column being written")

endmodule
